### rtl/hkrb_pkg.sv
// Package for the keyboard report builder: payload structs, codes and controller links.
// No dependencies.
package hkrb_pkg;

   localparam logic [2:0] MODE_USB     = 3'd0;
   localparam logic [2:0] MODE_CONS    = 3'd1;
   localparam logic [2:0] MODE_SYS     = 3'd2;
   localparam logic [2:0] MODE_BOOT    = 3'd3;
   localparam logic [2:0] MODE_NKRO    = 3'd4;
   localparam logic [2:0] MODE_SEND    = 3'd5;

   localparam logic [1:0] KS_PRESS     = 2'd1;
   localparam logic [1:0] KS_HOLD      = 2'd2;
   localparam logic [1:0] KS_RELEASE   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_IGN       = 3'd1;
   localparam logic [2:0] ST_LIMIT     = 3'd2;
   localparam logic [2:0] ST_BAD       = 3'd3;
   localparam logic [2:0] ST_NOTBOOT   = 3'd4;

   localparam logic [6:0] CH_MAIN = 7'h01;
   localparam logic [6:0] CH_SEC  = 7'h02;
   localparam logic [6:0] CH_TER  = 7'h04;
   localparam logic [6:0] CH_QUA  = 7'h08;
   localparam logic [6:0] CH_MOD  = 7'h10;
   localparam logic [6:0] CH_CONS = 7'h20;
   localparam logic [6:0] CH_SYS  = 7'h40;

   localparam int unsigned STORE_DEPTH = 32;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  key_state;
      logic [7:0]  state_type;
      logic [15:0] code;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  report_changes;
      logic [7:0]  report_modifiers;
      logic [7:0]  report_keys_sent;
      logic        report_protocol;
      logic [15:0] report_consumer;
      logic [7:0]  report_system;
      logic [4:0]  report_index;
      logic [7:0]  report_byte;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load;     // latch request
      logic       key_rd;   // read store byte addressed by the key's bit
      logic       exec;     // apply non-send command, emit one result
      logic       clear;    // clear one store entry at clr_index
      logic [4:0] clr_index;
      logic       send_rd;  // read store at send_index
      logic       send_out; // emit send result from read data
      logic [4:0] send_index;
      logic       send_last;
      logic       send_done;
   } cmd_type;

   typedef struct packed {
      logic       is_send;
      logic       proto;
      logic [7:0] key_count;
   } sts_type;

endpackage

### rtl/hkrb_datapath.sv
// Datapath of the keyboard report builder: state registers, key store memory, result register.
// Depends on hkrb_pkg.
module hkrb_datapath #(
   parameter int BOOT_KEYS  = 6,
   parameter int NKRO_BYTES = 27
) (
   input  logic             clock,
   input  logic             reset,
   input  hkrb_pkg::req_type req_in,
   input  hkrb_pkg::cmd_type cmd,
   output hkrb_pkg::sts_type sts,
   output logic             rsp_strobe,
   output hkrb_pkg::rsp_type rsp
);
   import hkrb_pkg::*;

   req_type     req_ff;
   logic        proto_ff, proto_in;
   logic [7:0]  mod_ff, mod_in;
   logic [7:0]  count_ff, count_in;
   logic [6:0]  chg_ff, chg_in;
   logic [15:0] cons_ff, cons_in;
   logic [7:0]  sys_ff, sys_in;
   logic        strobe_ff;
   rsp_type     rsp_ff;
   logic [7:0]  mem [STORE_DEPTH];
   logic [7:0]  rd_ff;
   logic [4:0]  idx_ff;
   logic        last_ff;

   // per-command store write
   logic        wr_en;
   logic [4:0]  wr_addr;
   logic [7:0]  wr_data;
   logic [2:0]  status;

   logic        normal, press, modkey;
   logic [7:0]  key;
   logic [7:0]  bitpos;
   logic [6:0]  flag;
   logic        inrange;
   logic        flush;
   logic        clr_all;

   assign sts.is_send   = (req_ff.mode == MODE_SEND);
   assign sts.proto     = proto_ff;
   assign sts.key_count = count_ff;

   always_comb begin
      key     = req_ff.code[7:0];
      normal  = (req_ff.state_type == 8'd0);
      press   = normal && (req_ff.key_state == KS_PRESS);
      modkey  = (key[7:5] == 3'b111);
      bitpos  = 8'd0;
      flag    = 7'd0;
      inrange = 1'b1;
      if (key >= 8'd4 && key <= 8'd49) begin
         bitpos = key - 8'd4;
         flag = CH_MAIN;
      end else if (key >= 8'd51 && key <= 8'd155) begin
         bitpos = key - 8'd3;
         flag = CH_SEC;
      end else if (key >= 8'd157 && key <= 8'd164) begin
         bitpos = key + 8'd3;
         flag = CH_TER;
      end else if (key >= 8'd176 && key <= 8'd221) begin
         bitpos = key - 8'd8;
         flag = CH_QUA;
      end else begin
         inrange = 1'b0;
      end
   end

   // NKRO bit update is a read-modify-write: rd_ff holds mem[bitpos>>3] read in the cycle
   // before exec.
   always_comb begin
      proto_in = proto_ff;
      mod_in   = mod_ff;
      count_in = count_ff;
      chg_in   = chg_ff;
      cons_in  = cons_ff;
      sys_in   = sys_ff;
      status   = ST_OK;
      wr_en    = 1'b0;
      wr_addr  = cmd.clr_index;
      wr_data  = 8'd0;
      flush    = 1'b0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end
      if (cmd.exec) begin
         unique case (req_ff.mode)
            MODE_USB: begin
               if (!proto_ff) begin
                  if (req_ff.key_state == KS_PRESS || req_ff.key_state == KS_RELEASE)
                     chg_in = CH_MAIN;
                  if (normal && req_ff.key_state == KS_RELEASE) begin
                     status = ST_IGN;
                  end else if (modkey) begin
                     if (key[4:3] == 2'b00) mod_in = mod_ff | (8'd1 << key[2:0]);
                  end else if (count_ff >= 8'(BOOT_KEYS)) begin
                     status = ST_LIMIT;
                  end else if (key > 8'd104) begin
                     status = ST_BAD;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[4:0];
                     wr_data  = key;
                     count_in = count_ff + 8'd1;
                  end
               end else if (normal && req_ff.key_state == KS_HOLD) begin
                  status = ST_IGN;
               end else if (modkey) begin
                  if (key[4:3] == 2'b00) begin
                     if (press) mod_in = mod_ff | (8'd1 << key[2:0]);
                     else       mod_in = mod_ff & ~(8'd1 << key[2:0]);
                  end
                  chg_in = chg_ff | CH_MOD;
               end else if (inrange) begin
                  chg_in  = chg_ff | flag;
                  wr_en   = 1'b1;
                  wr_addr = bitpos[7:3];
                  wr_data = press ? (rd_ff | (8'd1 << bitpos[2:0]))
                                  : (rd_ff & ~(8'd1 << bitpos[2:0]));
                  if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
               end else if (key == 8'd0) begin
                  chg_in = chg_ff | CH_MAIN;
                  flush  = 1'b1;
               end else begin
                  status = ST_BAD;
               end
            end
            MODE_CONS, MODE_SYS: begin
               if (!proto_ff) begin
                  status = ST_NOTBOOT;
               end else begin
                  if (req_ff.key_state == KS_PRESS || req_ff.key_state == KS_RELEASE)
                     chg_in = chg_ff | ((req_ff.mode == MODE_CONS) ? CH_CONS : CH_SYS);
                  if (req_ff.mode == MODE_CONS)
                     cons_in = (normal && req_ff.key_state == KS_RELEASE) ? 16'd0
                                                                        : req_ff.code;
                  else
                     sys_in = (normal && req_ff.key_state == KS_RELEASE) ? 8'd0
                                                                       : key;
               end
            end
            MODE_BOOT, MODE_NKRO: begin
               if (proto_ff == (req_ff.mode == MODE_NKRO) || !press) begin
                  status = ST_IGN;
               end else begin
                  flush    = 1'b1;
                  proto_in = (req_ff.mode == MODE_NKRO);
               end
            end
            default: status = ST_IGN;
         endcase
         if (flush) begin
            mod_in  = 8'd0;
            cons_in = 16'd0;
            sys_in  = 8'd0;
         end
      end
      if (cmd.send_done) begin
         count_in = 8'd0;
         chg_in   = 7'd0;
         if (!proto_ff) mod_in = 8'd0;
      end
   end

   assign clr_all = cmd.exec && flush;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_in;
      if (reset || clr_all) begin
         for (int i = 0; i < STORE_DEPTH; i++) mem[i] <= 8'd0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.send_rd) rd_ff <= mem[cmd.send_index];
      else if (cmd.key_rd) rd_ff <= mem[bitpos[7:3]];
      idx_ff  <= cmd.send_index;
      last_ff <= cmd.send_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff  <= 1'b1;
         mod_ff    <= 8'd0;
         count_ff  <= 8'd0;
         chg_ff    <= 7'd0;
         cons_ff   <= 16'd0;
         sys_ff    <= 8'd0;
         strobe_ff <= 1'b0;
      end else begin
         proto_ff  <= proto_in;
         mod_ff    <= mod_in;
         count_ff  <= count_in;
         chg_ff    <= chg_in;
         cons_ff   <= cons_in;
         sys_ff    <= sys_in;
         strobe_ff <= cmd.exec || cmd.send_out;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.status           <= status;
         rsp_ff.report_changes   <= chg_in;
         rsp_ff.report_modifiers <= mod_in;
         rsp_ff.report_keys_sent <= count_in;
         rsp_ff.report_protocol  <= proto_in;
         rsp_ff.report_consumer  <= cons_in;
         rsp_ff.report_system    <= sys_in;
         rsp_ff.report_index     <= 5'd0;
         rsp_ff.report_byte      <= 8'd0;
         rsp_ff.last             <= 1'b1;
      end else if (cmd.send_out) begin
         rsp_ff.status           <= ST_OK;
         rsp_ff.report_changes   <= chg_ff;
         rsp_ff.report_modifiers <= mod_ff;
         rsp_ff.report_keys_sent <= count_ff;
         rsp_ff.report_protocol  <= proto_ff;
         rsp_ff.report_consumer  <= cons_ff;
         rsp_ff.report_system    <= sys_ff;
         rsp_ff.report_index     <= idx_ff;
         rsp_ff.report_byte      <= rd_ff;
         rsp_ff.last             <= last_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   logic unused;
   assign unused = ^NKRO_BYTES[0];
endmodule

### rtl/hkrb_control.sv
// Controller of the keyboard report builder: sequences commands and sends.
// Depends on hkrb_pkg.
module hkrb_control #(
   parameter int BOOT_KEYS  = 6,
   parameter int NKRO_BYTES = 27
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hkrb_pkg::req_type  req_in,
   input  hkrb_pkg::sts_type  sts,
   output hkrb_pkg::cmd_type  cmd
);
   import hkrb_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_EXEC  = 6'b000100,
      S_CLEAR = 6'b001000,
      S_SEND  = 6'b010000,
      S_DRAIN = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [4:0] endc_ff, endc_in;
   logic [4:0] nsend;

   assign nsend = sts.proto ? 5'(NKRO_BYTES - 1) : 5'(BOOT_KEYS - 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      endc_in  = endc_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) state_in = S_READ;
         end
         S_READ: begin
            if (sts.is_send) begin
               cnt_in = 5'd0;
               if (!sts.proto && sts.key_count < 8'(BOOT_KEYS)) begin
                  cnt_in   = sts.key_count[4:0];
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_SEND;
               end
            end else begin
               // bitmap byte for the addressed bit is read here
               cmd.key_rd = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear     = 1'b1;
            cmd.clr_index = cnt_ff;
            if (cnt_ff == 5'(BOOT_KEYS - 1)) begin
               cnt_in   = 5'd0;
               state_in = S_SEND;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SEND: begin
            cmd.send_rd    = 1'b1;
            cmd.send_index = cnt_ff;
            cmd.send_last  = (cnt_ff == nsend);
            cmd.send_out   = (cnt_ff != 5'd0) || (endc_ff != 5'd0);
            endc_in        = 5'd1;
            if (cnt_ff == nsend) state_in = S_DRAIN;
            else cnt_in = cnt_ff + 5'd1;
         end
         S_DRAIN: begin
            cmd.send_out  = 1'b1;
            cmd.send_done = 1'b1;
            endc_in       = 5'd0;
            cnt_in        = 5'd0;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
         endc_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         endc_ff  <= endc_in;
      end
   end

   logic unused;
   assign unused = ^req_in;
endmodule

### rtl/hid_keyboard_report_builder.sv
// Top level of the keyboard report builder: controller plus datapath.
// Depends on hkrb_pkg, hkrb_control, hkrb_datapath.
// One item at a time; busy marks it. Key event or command: latched on start, its store byte
// read in S_READ, applied in S_EXEC; its one result strobe is registered. Send: BOOT_KEYS
// or NKRO_BYTES bytes, one per cycle from the store port; boot first zeroes unused entries.
// Synchronous active-high reset restores NKRO mode and clears the state and the key store.
module hid_keyboard_report_builder #(
   parameter int BOOT_KEYS  = 6,
   parameter int NKRO_BYTES = 27
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hkrb_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output hkrb_pkg::rsp_type  rsp_data
);
   import hkrb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hkrb_control #(.BOOT_KEYS(BOOT_KEYS), .NKRO_BYTES(NKRO_BYTES)) u_ctrl (
      .clock, .reset, .start, .busy, .req_in(req_data), .sts, .cmd
   );

   hkrb_datapath #(.BOOT_KEYS(BOOT_KEYS), .NKRO_BYTES(NKRO_BYTES)) u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .sts, .rsp_strobe, .rsp(rsp_data)
   );
endmodule

### bench/tb_hid_keyboard_report_builder.sv
// Self-checking bench for hid_keyboard_report_builder: key events and commands in,
// report results checked against an in-bench model. Depends on hkrb_pkg and the RTL.
module tb_hid_keyboard_report_builder;
   import hkrb_pkg::*;

   localparam int BOOT_KEYS  = 6;
   localparam int NKRO_BYTES = 27;
   localparam int WATCHDOG   = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   hid_keyboard_report_builder #(.BOOT_KEYS(BOOT_KEYS), .NKRO_BYTES(NKRO_BYTES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // model state
   logic       m_proto;
   logic [7:0] m_mods;
   logic [7:0] m_store [NKRO_BYTES];
   logic [7:0] m_count;
   logic [6:0] m_changes;
   logic [15:0] m_consumer;
   logic [7:0] m_system;

   req_type pending_events [$];
   rsp_type expected_reports [$];
   int errors = 0;
   int events_sent = 0;
   int reports_seen = 0;
   int sends_seen = 0;
   int idle_cycles = 0;
   bit stim_done = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h want %0h (report %0d)", what, got, want, reports_seen);
      errors++;
   endtask

   function automatic void model_reset();
      m_proto = 1'b1;
      m_mods = '0;
      foreach (m_store[i]) m_store[i] = '0;
      m_count = '0;
      m_changes = '0;
      m_consumer = '0;
      m_system = '0;
   endfunction

   function automatic void model_flush();
      foreach (m_store[i]) m_store[i] = '0;
      m_consumer = '0;
      m_mods = '0;
      m_system = '0;
   endfunction

   function automatic void push_report(logic [2:0] status, logic [4:0] idx, logic [7:0] b,
                                       logic lst);
      rsp_type r;
      r.status = status;
      r.report_changes = m_changes;
      r.report_modifiers = m_mods;
      r.report_keys_sent = m_count;
      r.report_protocol = m_proto;
      r.report_consumer = m_consumer;
      r.report_system = m_system;
      r.report_index = idx;
      r.report_byte = b;
      r.last = lst;
      expected_reports.push_back(r);
   endfunction

   function automatic logic [2:0] model_usb(logic [1:0] ks, logic [7:0] st, logic [7:0] key);
      logic normal;
      logic press;
      int bitpos;
      logic [6:0] flag;
      normal = (st == 8'd0);
      if (!m_proto) begin
         if (ks == KS_PRESS || ks == KS_RELEASE) m_changes = CH_MAIN;
         if (normal && ks == KS_RELEASE) return ST_IGN;
         if (key[7:5] == 3'b111) begin
            if (key[4:3] == 2'b00) m_mods[key[2:0]] = 1'b1;
            return ST_OK;
         end
         if (m_count >= BOOT_KEYS) return ST_LIMIT;
         if (key > 8'd104) return ST_BAD;
         m_store[m_count % NKRO_BYTES] = key;
         m_count++;
         return ST_OK;
      end
      if (normal && ks == KS_HOLD) return ST_IGN;
      press = normal && ks == KS_PRESS;
      if (key[7:5] == 3'b111) begin
         if (key[4:3] == 2'b00) m_mods[key[2:0]] = press;
         m_changes |= CH_MOD;
         return ST_OK;
      end
      if (key >= 4 && key <= 49) begin
         bitpos = key - 4; flag = CH_MAIN;
      end else if (key >= 51 && key <= 155) begin
         bitpos = key - 51 + 48; flag = CH_SEC;
      end else if (key >= 157 && key <= 164) begin
         bitpos = key - 157 + 160; flag = CH_TER;
      end else if (key >= 176 && key <= 221) begin
         bitpos = key - 176 + 168; flag = CH_QUA;
      end else if (key == 0) begin
         m_changes |= CH_MAIN;
         model_flush();
         return ST_OK;
      end else begin
         return ST_BAD;
      end
      m_changes |= flag;
      m_store[(bitpos >> 3) % NKRO_BYTES][bitpos & 7] = press;
      if (m_count != 8'd255) m_count++;
      return ST_OK;
   endfunction

   function automatic void model_event(req_type q);
      logic normal;
      logic [2:0] status;
      logic target;
      int n;
      normal = (q.state_type == 8'd0);
      status = ST_OK;
      case (q.mode)
         MODE_USB: status = model_usb(q.key_state, q.state_type, q.code[7:0]);
         MODE_CONS, MODE_SYS: begin
            if (!m_proto) status = ST_NOTBOOT;
            else begin
               if (q.key_state == KS_PRESS || q.key_state == KS_RELEASE)
                  m_changes |= (q.mode == MODE_CONS) ? CH_CONS : CH_SYS;
               if (q.mode == MODE_CONS)
                  m_consumer = (normal && q.key_state == KS_RELEASE) ? 16'd0 : q.code;
               else
                  m_system = (normal && q.key_state == KS_RELEASE) ? 8'd0 : q.code[7:0];
            end
         end
         MODE_BOOT, MODE_NKRO: begin
            target = (q.mode == MODE_NKRO);
            if (m_proto == target || !(normal && q.key_state == KS_PRESS)) status = ST_IGN;
            else begin
               model_flush();
               m_proto = target;
            end
         end
         MODE_SEND: begin
            if (!m_proto) begin
               for (int k = m_count; k < BOOT_KEYS; k++) m_store[k] = '0;
               n = BOOT_KEYS;
            end else n = NKRO_BYTES;
            for (int k = 0; k < n; k++) push_report(ST_OK, k[4:0], m_store[k], k == n - 1);
            m_count = '0;
            m_changes = '0;
            if (!m_proto) m_mods = '0;
            return;
         end
         default: status = ST_IGN;
      endcase
      push_report(status, 5'd0, 8'd0, 1'b1);
   endfunction

   function automatic req_type make_event(logic [2:0] mode, logic [1:0] ks, logic [7:0] st,
                                          logic [15:0] code);
      req_type q;
      q.mode = mode; q.key_state = ks; q.state_type = st; q.code = code;
      return q;
   endfunction

   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 9))
         0: return {8'($urandom), 8'($urandom_range(8'hE0, 8'hFF))};
         1: return 16'($urandom);
         2: return 16'd0;
         default: return 16'($urandom_range(0, 230));
      endcase
   endfunction

   // driver
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else if (start && !busy) begin
         model_event(req_data);
         events_sent++;
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         if (gap == 0 && pending_events.size() != 0) begin
            req_data <= pending_events.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap > 0) gap--;
         else if (pending_events.size() != 0) begin
            req_data <= pending_events.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $display("unexpected report %0d", reports_seen);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.report_changes !== want.report_changes)
               report_mismatch("changes", rsp_data.report_changes, want.report_changes);
            if (rsp_data.report_modifiers !== want.report_modifiers)
               report_mismatch("modifiers", rsp_data.report_modifiers, want.report_modifiers);
            if (rsp_data.report_keys_sent !== want.report_keys_sent)
               report_mismatch("keys_sent", rsp_data.report_keys_sent, want.report_keys_sent);
            if (rsp_data.report_protocol !== want.report_protocol)
               report_mismatch("protocol", rsp_data.report_protocol, want.report_protocol);
            if (rsp_data.report_consumer !== want.report_consumer)
               report_mismatch("consumer", rsp_data.report_consumer, want.report_consumer);
            if (rsp_data.report_system !== want.report_system)
               report_mismatch("system", rsp_data.report_system, want.report_system);
            if (rsp_data.report_index !== want.report_index)
               report_mismatch("index", rsp_data.report_index, want.report_index);
            if (rsp_data.report_byte !== want.report_byte)
               report_mismatch("byte", rsp_data.report_byte, want.report_byte);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
            if (want.last && want.report_index != 0) sends_seen++;
         end
         reports_seen++;
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG);
         $display("** hid_keyboard_report_builder: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [2:0] mode;
      logic [1:0] ks;
      logic [7:0] st;
      int r;
      model_reset();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: NKRO extremes, modifiers, consumer/system, boot limits, bad modes
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h0004));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'hFF31));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h009B));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h00A4));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h00DD));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h00E7));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h00FF));
      pending_events.push_back(make_event(MODE_USB, KS_HOLD, 8'd0, 16'h0032));
      pending_events.push_back(make_event(MODE_USB, KS_RELEASE, 8'hFF, 16'h00DE));
      pending_events.push_back(make_event(MODE_CONS, KS_PRESS, 8'd0, 16'hFFFF));
      pending_events.push_back(make_event(MODE_SYS, 2'd0, 8'd7, 16'h00FF));
      pending_events.push_back(make_event(MODE_SEND, 2'd0, 8'd0, 16'd0));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'h0000));
      pending_events.push_back(make_event(MODE_BOOT, KS_PRESS, 8'd0, 16'd0));
      pending_events.push_back(make_event(MODE_CONS, KS_PRESS, 8'd0, 16'h1234));
      pending_events.push_back(make_event(MODE_USB, KS_RELEASE, 8'd0, 16'h0004));
      pending_events.push_back(make_event(MODE_USB, KS_HOLD, 8'd1, 16'h00E1));
      for (int i = 0; i < 6; i++)
         pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'd100 + i));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'd5));
      pending_events.push_back(make_event(MODE_SEND, 2'd0, 8'd0, 16'd0));
      pending_events.push_back(make_event(MODE_USB, KS_PRESS, 8'd0, 16'd105));
      pending_events.push_back(make_event(3'd6, KS_PRESS, 8'd0, 16'd0));
      pending_events.push_back(make_event(3'd7, KS_PRESS, 8'd0, 16'd0));
      pending_events.push_back(make_event(MODE_NKRO, KS_PRESS, 8'd0, 16'd0));

      // random: mostly key events, with sends and protocol switches mixed in
      for (int i = 0; i < 445; i++) begin
         r = $urandom_range(0, 99);
         ks = 2'($urandom);
         st = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0;
         if (r < 62) mode = MODE_USB;
         else if (r < 72) mode = MODE_CONS;
         else if (r < 80) mode = MODE_SYS;
         else if (r < 86) mode = MODE_BOOT;
         else if (r < 92) mode = MODE_NKRO;
         else if (r < 98) mode = MODE_SEND;
         else mode = 3'($urandom_range(6, 7));
         if (mode == MODE_BOOT || mode == MODE_NKRO) begin
            if ($urandom_range(0, 2) != 0) begin ks = KS_PRESS; st = 8'd0; end
         end
         pending_events.push_back(make_event(mode, ks, st,
            mode == MODE_USB ? pick_key() : 16'($urandom)));
      end
      stim_done = 1;

      wait (pending_events.size() == 0 && !start && expected_reports.size() == 0);
      repeat (40) @(posedge clock);
      $display("ran %0d key events and commands, %0d sends, %0d report transfers checked",
               events_sent, sends_seen, reports_seen);
      if (errors == 0 && expected_reports.size() == 0)
         $display("** hid_keyboard_report_builder: PASSED **");
      else
         $display("** hid_keyboard_report_builder: FAILED **");
      $finish;
   end

endmodule
